// ===== design/ldf_pkg.sv =====
package ldf_pkg;

  localparam int OFFSET_BITS    = 40;
  localparam int FIRST_SEQUENCE = 1;
  localparam int HDR_BYTES      = 28;
  localparam int CRC_COVERED    = 24;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_RECORD  = 2'd1;
  localparam logic [1:0] KIND_LOG_END = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_OP        = 3'd3;
  localparam logic [2:0] ERR_SEQUENCE  = 3'd4;
  localparam logic [2:0] ERR_LENGTHS   = 3'd5;
  localparam logic [2:0] ERR_CRC       = 3'd6;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd7;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] REG_MAGIC     = 3'd0;
  localparam logic [2:0] REG_VERSION   = 3'd1;
  localparam logic [2:0] REG_OP_SET    = 3'd2;
  localparam logic [2:0] REG_OP_DELETE = 3'd3;
  localparam logic [2:0] REG_OP_CLEAR  = 3'd4;
  localparam logic [2:0] REG_MAX_KEY   = 3'd5;
  localparam logic [2:0] REG_MAX_VALUE = 3'd6;
  localparam logic [2:0] REG_MAX_LOG   = 3'd7;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [15:0] op_code_set;
    logic [15:0] op_code_delete;
    logic [15:0] op_code_clear;
    logic [15:0] max_key_len;
    logic [31:0] max_value_len;
    logic [39:0] max_log_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        in_value;
    logic [1:0]  operation;
    logic [63:0] seq_number;
    logic [15:0] key_len;
    logic [31:0] value_len;
    logic [39:0] tail_bytes;
    logic [2:0]  fault_code;
    logic [39:0] record_offset;
    logic        last_of_run;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t mk_error(input logic [2:0] code, input logic [39:0] offset);
    res_t r;
    r = '0;
    r.result_kind   = KIND_ERROR;
    r.fault_code    = code;
    r.record_offset = offset;
    return r;
  endfunction

endpackage

// ===== design/ldf_result_queue.sv =====
module ldf_result_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_count,
  input  ldf_pkg::res_t push_first,
  input  ldf_pkg::res_t push_second,
  output logic          room_for_two,
  output logic          out_valid,
  input  logic          out_stall,
  output ldf_pkg::res_t out_res
);

  ldf_pkg::res_t q_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] wr_next_slot;

  assign pop          = (cnt_r != 3'd0) && !out_stall;
  assign out_valid    = (cnt_r != 3'd0);
  assign out_res      = q_r[rd_r];
  assign room_for_two = (cnt_r <= 3'd2);
  assign wr_next_slot = wr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      q_r[wr_r] <= push_first;
    end
    if (push_count == 2'd2) begin
      q_r[wr_next_slot] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_count;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push_count} - {2'b0, pop};
    end
  end

endmodule

// ===== design/ldf_core.sv =====
module ldf_core (
  input  logic          clk,
  input  logic          rst_n,
  input  ldf_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic          req_type,
  input  logic [7:0]    log_byte,
  output logic [1:0]    res_count,
  output ldf_pkg::res_t res_first,
  output ldf_pkg::res_t res_second
);

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_ERROR} phase_t;

  localparam int OB = ldf_pkg::OFFSET_BITS;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  hdr_r [ldf_pkg::HDR_BYTES];
  logic        hdr_we;
  logic [31:0] crc_r, crc_nxt;
  logic [32:0] pidx_r, pidx_nxt;
  logic [32:0] total_r, total_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [OB-1:0] offs_r, offs_nxt, bound_r, bound_nxt;
  logic [2:0]  sticky_r, sticky_nxt;

  logic [31:0] f_magic, f_klen, f_vlen, f_crc_stored, f_crc_hdr;
  logic [15:0] f_ver, f_raw;
  logic [63:0] f_seq;
  logic [1:0]  dec_op;
  logic        op_known, len_bad;
  logic [2:0]  hdr_code;
  logic [31:0] crc_pay;
  logic [OB-1:0] offs_inc;
  logic        too_large;
  ldf_pkg::res_t done_res;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      f_magic[8*k +: 8]      = hdr_r[k];
      f_klen[8*k +: 8]       = hdr_r[16 + k];
      f_vlen[8*k +: 8]       = hdr_r[20 + k];
      f_crc_stored[8*k +: 8] = hdr_r[24 + k];
    end
    for (int k = 0; k < 8; k++) begin
      f_seq[8*k +: 8] = hdr_r[8 + k];
    end
    f_ver     = {hdr_r[5], hdr_r[4]};
    f_raw     = {hdr_r[7], hdr_r[6]};
    f_crc_hdr = {log_byte, hdr_r[26], hdr_r[25], hdr_r[24]};
  end

  // Set wins over delete, delete over clear when codes overlap.
  always_comb begin
    op_known = 1'b1;
    if (f_raw == cfg.op_code_set) begin
      dec_op = ldf_pkg::OP_SET;
    end else if (f_raw == cfg.op_code_delete) begin
      dec_op = ldf_pkg::OP_DELETE;
    end else if (f_raw == cfg.op_code_clear) begin
      dec_op = ldf_pkg::OP_CLEAR;
    end else begin
      dec_op   = ldf_pkg::OP_CLEAR;
      op_known = 1'b0;
    end
    case (dec_op)
      ldf_pkg::OP_SET: len_bad = (f_klen == 32'd0) || (f_klen > {16'd0, cfg.max_key_len})
                                 || (f_vlen > cfg.max_value_len);
      ldf_pkg::OP_DELETE: len_bad = (f_klen == 32'd0) || (f_klen > {16'd0, cfg.max_key_len})
                                    || (f_vlen != 32'd0);
      default: len_bad = (f_klen != 32'd0) || (f_vlen != 32'd0);
    endcase
    if (f_magic != cfg.magic_word) begin
      hdr_code = ldf_pkg::ERR_MAGIC;
    end else if (f_ver != cfg.format_version) begin
      hdr_code = ldf_pkg::ERR_VERSION;
    end else if (!op_known) begin
      hdr_code = ldf_pkg::ERR_OP;
    end else if (f_seq != seq_r) begin
      hdr_code = ldf_pkg::ERR_SEQUENCE;
    end else if (len_bad) begin
      hdr_code = ldf_pkg::ERR_LENGTHS;
    end else begin
      hdr_code = ldf_pkg::ERR_NONE;
    end
  end

  assign crc_pay   = ldf_pkg::crc_byte(crc_r, log_byte);
  assign offs_inc  = offs_r + 1'b1;
  assign too_large = ({{(64-OB){1'b0}}, offs_r} >= {24'd0, cfg.max_log_bytes})
                     || (offs_r == {OB{1'b1}});

  always_comb begin
    done_res               = '0;
    done_res.result_kind   = ldf_pkg::KIND_RECORD;
    done_res.operation     = op_nxt;
    done_res.seq_number    = f_seq;
    done_res.key_len       = f_klen[15:0];
    done_res.value_len     = f_vlen;
    done_res.record_offset = 40'(bound_r);
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hdr_we     = 1'b0;
    crc_nxt    = crc_r;
    pidx_nxt   = pidx_r;
    total_nxt  = total_r;
    op_nxt     = op_r;
    seq_nxt    = seq_r;
    offs_nxt   = offs_r;
    bound_nxt  = bound_r;
    sticky_nxt = sticky_r;
    res_count  = 2'd0;
    res_first  = '0;
    res_second = '0;
    if (accept) begin
      if (req_type) begin
        res_first.result_kind   = ldf_pkg::KIND_LOG_END;
        res_first.seq_number    = (seq_r == 64'(ldf_pkg::FIRST_SEQUENCE)) ? 64'd0
                                                                          : seq_r - 64'd1;
        res_first.tail_bytes    = (sticky_r != ldf_pkg::ERR_NONE) ? 40'd0
                                                                  : 40'(offs_r - bound_r);
        res_first.fault_code    = sticky_r;
        res_first.record_offset = 40'(bound_r);
        res_count  = 2'd1;
        phase_nxt  = PH_HEADER;
        hcnt_nxt   = '0;
        crc_nxt    = '1;
        seq_nxt    = 64'(ldf_pkg::FIRST_SEQUENCE);
        offs_nxt   = '0;
        bound_nxt  = '0;
        sticky_nxt = ldf_pkg::ERR_NONE;
      end else if (phase_r == PH_ERROR) begin
        res_count = 2'd0;
      end else if (too_large) begin
        res_first  = ldf_pkg::mk_error(ldf_pkg::ERR_TOO_LARGE, 40'(bound_r));
        res_count  = 2'd1;
        phase_nxt  = PH_ERROR;
        sticky_nxt = ldf_pkg::ERR_TOO_LARGE;
      end else begin
        offs_nxt = offs_inc;
        if (phase_r == PH_HEADER) begin
          hdr_we   = 1'b1;
          hcnt_nxt = hcnt_r + 5'd1;
          if (hcnt_r < 5'(ldf_pkg::CRC_COVERED)) begin
            crc_nxt = crc_pay;
          end
          if (hcnt_r == 5'(ldf_pkg::HDR_BYTES - 1)) begin
            hcnt_nxt  = '0;
            total_nxt = {1'b0, f_klen} + {1'b0, f_vlen};
            op_nxt    = dec_op;
            if (hdr_code != ldf_pkg::ERR_NONE) begin
              res_first  = ldf_pkg::mk_error(hdr_code, 40'(bound_r));
              res_count  = 2'd1;
              phase_nxt  = PH_ERROR;
              sticky_nxt = hdr_code;
            end else if (total_nxt == 33'd0) begin
              res_count = 2'd1;
              if (~crc_r != f_crc_hdr) begin
                res_first  = ldf_pkg::mk_error(ldf_pkg::ERR_CRC, 40'(bound_r));
                phase_nxt  = PH_ERROR;
                sticky_nxt = ldf_pkg::ERR_CRC;
              end else begin
                res_first = done_res;
                bound_nxt = offs_inc;
                seq_nxt   = seq_r + 64'd1;
                crc_nxt   = '1;
              end
            end else begin
              phase_nxt = PH_PAYLOAD;
              pidx_nxt  = '0;
            end
          end
        end else begin
          crc_nxt                = crc_pay;
          res_first.result_kind  = ldf_pkg::KIND_PAYLOAD;
          res_first.payload_byte = log_byte;
          res_first.in_value     = (pidx_r >= {1'b0, f_klen});
          res_count              = 2'd1;
          pidx_nxt               = pidx_r + 33'd1;
          if (pidx_nxt >= total_r) begin
            res_count = 2'd2;
            if (~crc_pay != f_crc_stored) begin
              res_second = ldf_pkg::mk_error(ldf_pkg::ERR_CRC, 40'(bound_r));
              phase_nxt  = PH_ERROR;
              sticky_nxt = ldf_pkg::ERR_CRC;
            end else begin
              res_second = done_res;
              bound_nxt  = offs_inc;
              seq_nxt    = seq_r + 64'd1;
              crc_nxt    = '1;
              phase_nxt  = PH_HEADER;
              hcnt_nxt   = '0;
            end
          end
        end
      end
      if (res_count == 2'd1) begin
        res_first.last_of_run = 1'b1;
      end
      if (res_count == 2'd2) begin
        res_second.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hcnt_r] <= log_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcnt_r   <= '0;
      crc_r    <= '1;
      pidx_r   <= '0;
      total_r  <= '0;
      op_r     <= ldf_pkg::OP_SET;
      seq_r    <= 64'(ldf_pkg::FIRST_SEQUENCE);
      offs_r   <= '0;
      bound_r  <= '0;
      sticky_r <= ldf_pkg::ERR_NONE;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      crc_r    <= crc_nxt;
      pidx_r   <= pidx_nxt;
      total_r  <= total_nxt;
      op_r     <= op_nxt;
      seq_r    <= seq_nxt;
      offs_r   <= offs_nxt;
      bound_r  <= bound_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

// ===== design/log_record_deframer.sv =====
// Record log deframer.
// The input channel carries one item per log byte (in_req_type low) and a final
// end-of-log item (in_req_type high). Each record is a 28-byte little-endian
// header followed by its key and value bytes; the header is checked once it is
// complete and the payload bytes are then forwarded one result per item.
// The result channel carries payload bytes, record-done reports, errors and the
// end-of-log summary; out_last_of_run marks the last result caused by an item.
// An item's results are written into the result queue at the edge that accepts
// it. One item is accepted every cycle while in_stall is low: the per-byte
// CRC step, header capture and header checks all fit between the state
// registers and a four-entry result queue. The last payload byte of a record
// produces two results, so under sustained traffic the output side sets the
// pace whenever records finish.
// in_stall rises when the result queue holds three or more results, i.e. when
// it could not take the two results of a worst-case item; a stalled receiver
// thus fills the queue and then holds off the sender, and no result is lost.
// Reset (rst_n low at a clock edge) restores the configuration registers to
// their defaults, empties the queue and restarts the log state.
// The user must write the configuration port only while idle; nothing enforces it.
module log_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_log_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_in_value,
  output logic [1:0]  out_operation,
  output logic [63:0] out_seq_number,
  output logic [15:0] out_key_len,
  output logic [31:0] out_value_len,
  output logic [39:0] out_tail_bytes,
  output logic [2:0]  out_error_code,
  output logic [39:0] out_record_offset,
  output logic        out_last_of_run
);

  ldf_pkg::cfg_t cfg_r;
  logic          accept;
  logic          room_for_two;
  logic [1:0]    res_count;
  ldf_pkg::res_t res_first, res_second, out_res;

  // Configuration registers; an unknown index cannot occur with a three-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word     <= 32'd0;
      cfg_r.format_version <= 16'd1;
      cfg_r.op_code_set    <= 16'd1;
      cfg_r.op_code_delete <= 16'd2;
      cfg_r.op_code_clear  <= 16'd3;
      cfg_r.max_key_len    <= 16'd1024;
      cfg_r.max_value_len  <= 32'd1048576;
      cfg_r.max_log_bytes  <= 40'd67108864;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldf_pkg::REG_MAGIC:     cfg_r.magic_word     <= cfg_wdata[31:0];
        ldf_pkg::REG_VERSION:   cfg_r.format_version <= cfg_wdata[15:0];
        ldf_pkg::REG_OP_SET:    cfg_r.op_code_set    <= cfg_wdata[15:0];
        ldf_pkg::REG_OP_DELETE: cfg_r.op_code_delete <= cfg_wdata[15:0];
        ldf_pkg::REG_OP_CLEAR:  cfg_r.op_code_clear  <= cfg_wdata[15:0];
        ldf_pkg::REG_MAX_KEY:   cfg_r.max_key_len    <= cfg_wdata[15:0];
        ldf_pkg::REG_MAX_VALUE: cfg_r.max_value_len  <= cfg_wdata[31:0];
        ldf_pkg::REG_MAX_LOG:   cfg_r.max_log_bytes  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The stall depends only on the queue fill, never on the item itself.
  assign in_stall = !room_for_two;
  assign accept   = in_valid && !in_stall;

  ldf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .req_type   (in_req_type),
    .log_byte   (in_log_byte),
    .res_count  (res_count),
    .res_first  (res_first),
    .res_second (res_second)
  );

  ldf_result_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_count   (res_count),
    .push_first   (res_first),
    .push_second  (res_second),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (out_res)
  );

  assign out_result_kind   = out_res.result_kind;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_in_value      = out_res.in_value;
  assign out_operation     = out_res.operation;
  assign out_seq_number    = out_res.seq_number;
  assign out_key_len       = out_res.key_len;
  assign out_value_len     = out_res.value_len;
  assign out_tail_bytes    = out_res.tail_bytes;
  assign out_error_code    = out_res.fault_code;
  assign out_record_offset = out_res.record_offset;
  assign out_last_of_run   = out_res.last_of_run;

endmodule

// ===== design/ldf_checker.sv =====
module ldf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_payload_byte,
  input logic [2:0]  out_error_code,
  input logic [39:0] out_tail_bytes,
  input logic        out_last_of_run
);

  // A stalled result stays offered, with its kind and payload byte unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
                               && $stable(out_result_kind))
    else $error("stalled result changed");

  // An end-of-log summary is always the only result of its item.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ldf_pkg::KIND_LOG_END |-> out_last_of_run)
    else $error("log end not last of run");

  // An error result carries a real code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ldf_pkg::KIND_ERROR |-> out_error_code != ldf_pkg::ERR_NONE)
    else $error("error result without code");

  // A payload byte carries no error code and no tail count.
  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ldf_pkg::KIND_PAYLOAD
      |-> out_error_code == ldf_pkg::ERR_NONE && out_tail_bytes == 40'd0)
    else $error("payload result has stray fields");

endmodule

bind log_record_deframer ldf_checker u_ldf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_payload_byte (out_payload_byte),
  .out_error_code   (out_error_code),
  .out_tail_bytes   (out_tail_bytes),
  .out_last_of_run  (out_last_of_run)
);
